/* design/txc_pkg.sv */
// Shared types and constants for the text console writer.
// Holds the transfer payload structs, operation and state codes, and the
// command/status structs between the controller and the datapath.
package txc_pkg;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'd15;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } txc_op_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic [10:0] cell_index;
  } txc_in_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [4:0]  cursor_line;
    logic [6:0]  cursor_column;
    logic        did_scroll;
    logic [7:0]  cell_char;
    logic [7:0]  cell_color;
  } txc_out_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_SCROLL,
    ST_FILL,
    ST_READ,
    ST_EMIT
  } txc_state_t;

  typedef struct packed {
    logic load;        // latch the accepted item
    logic clr_start;   // home cursor, arm the fill sweep with the live attribute
    logic put;         // write the character and move the cursor
    logic scroll_step; // one step of the scroll sweep
    logic fill_step;   // one step of the blank fill
    logic read_issue;  // issue the cell read
    logic emit;        // load the result register
  } txc_cmd_t;

  typedef struct packed {
    logic put_scroll;
    logic sweep_last;
    logic fill_last;
    logic out_free;
  } txc_status_t;

endpackage

/* design/txc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module txc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/txc_ctrl.sv */
// Controller state machine for the text console writer.
// Uses txc_pkg; drives txc_cmd_t into the datapath and reads txc_status_t.
module txc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           in_op,
  output logic                 in_stall,
  input  txc_pkg::txc_status_t status,
  output txc_pkg::txc_cmd_t    cmd,
  output txc_pkg::txc_state_t  state
);
  import txc_pkg::*;

  txc_state_t state_next;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_INIT: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          case (txc_op_t'(in_op))
            OP_PUT: begin
              state_next = ST_PUT;
            end
            OP_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_next    = ST_FILL;
            end
            OP_READ: begin
              state_next = ST_READ;
            end
            default: begin
              state_next = ST_EMIT;
            end
          endcase
        end
      end
      ST_PUT: begin
        cmd.put = 1'b1;
        state_next = status.put_scroll ? ST_SCROLL : ST_EMIT;
      end
      ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_READ: begin
        cmd.read_issue = 1'b1;
        state_next     = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the result register is free
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* design/txc_dp.sv */
// Datapath for the text console writer: cursor, item registers, sweep counter,
// screen store (txc_ram) and the result register. Uses txc_pkg.
module txc_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [7:0]           cfg_data,
  input  txc_pkg::txc_in_t     in_data,
  input  txc_pkg::txc_cmd_t    cmd,
  output txc_pkg::txc_status_t status,
  input  logic                 out_stall,
  output logic                 out_valid,
  output txc_pkg::txc_out_t    out_data
);
  import txc_pkg::*;

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int POS_W     = $clog2(CELLS);
  localparam int CNT_W     = $clog2(CELLS + COLUMNS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

  logic [7:0]       blank_attr;
  logic             fill_cfg;
  txc_in_t          item;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [POS_W-1:0] base;
  logic             scrolled;
  logic [CNT_W-1:0] cnt;

  // delayed write stage of the scroll sweep
  logic             sw_v;
  logic             sw_copy;
  logic [POS_W-1:0] sw_dst;

  logic             is_nl;
  logic             last_col;
  logic             last_row;
  logic             wrap;
  logic             idx_ok;
  logic             cnt_in_store;
  logic [7:0]       fill_attr;

  logic             mem_we;
  logic [POS_W-1:0] mem_waddr;
  logic [15:0]      mem_wdata;
  logic             mem_re;
  logic [POS_W-1:0] mem_raddr;
  logic [15:0]      mem_rdata;

  logic [31:0]      pos_ext;
  logic [31:0]      row_ext;
  logic [31:0]      col_ext;

  assign is_nl        = (item.char_code == NEWLINE_CODE);
  assign last_col     = (32'(col) == COLUMNS - 1);
  assign last_row     = (32'(row) == ROWS - 1);
  assign wrap         = is_nl || last_col;
  assign idx_ok       = (32'(item.cell_index) < CELLS);
  assign cnt_in_store = (32'(cnt) < CELLS);
  assign fill_attr    = fill_cfg ? blank_attr : RESET_ATTR;

  assign status.put_scroll = wrap && last_row;
  assign status.sweep_last = (32'(cnt) == CELLS + COLUMNS - 1);
  assign status.fill_last  = (32'(cnt) == CELLS - 1);
  assign status.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_attr <= RESET_ATTR;
    end else if (cfg_write) begin
      blank_attr <= cfg_data;
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
  end

  // cursor, sweep counter and fill source
  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      col      <= '0;
      base     <= '0;
      scrolled <= 1'b0;
      cnt      <= '0;
      fill_cfg <= 1'b0;
      sw_v     <= 1'b0;
    end else begin
      sw_v <= cmd.scroll_step;
      if (cmd.load) begin
        scrolled <= 1'b0;
      end
      if (cmd.clr_start) begin
        row      <= '0;
        col      <= '0;
        base     <= '0;
        cnt      <= '0;
        fill_cfg <= 1'b1;
      end
      if (cmd.put) begin
        if (wrap) begin
          col <= '0;
          if (last_row) begin
            base     <= POS_W'(LAST_BASE);
            scrolled <= 1'b1;
            cnt      <= CNT_W'(COLUMNS);
          end else begin
            row  <= row + 1'b1;
            base <= base + POS_W'(COLUMNS);
          end
        end else begin
          col <= col + 1'b1;
        end
      end
      if (cmd.fill_step || cmd.scroll_step) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sw_copy <= cnt_in_store;
    sw_dst  <= POS_W'(cnt - CNT_W'(COLUMNS));
  end

  // write port: one user at a time by controller state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = base + POS_W'(col);
    mem_wdata = {item.attribute, item.char_code};
    if (sw_v) begin
      mem_we    = 1'b1;
      mem_waddr = sw_dst;
      mem_wdata = sw_copy ? mem_rdata : {blank_attr, BLANK_CHAR};
    end else if (cmd.put) begin
      mem_we = !is_nl;
    end else if (cmd.fill_step) begin
      mem_we    = 1'b1;
      mem_waddr = POS_W'(cnt);
      mem_wdata = {fill_attr, BLANK_CHAR};
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = POS_W'(item.cell_index);
    if (cmd.scroll_step) begin
      mem_re    = cnt_in_store;
      mem_raddr = POS_W'(cnt);
    end else if (cmd.read_issue) begin
      mem_re = idx_ok;
    end
  end

  txc_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign pos_ext = 32'(base) + 32'(col);
  assign row_ext = 32'(row);
  assign col_ext = 32'(col);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.cursor_position <= pos_ext[10:0];
      out_data.cursor_line     <= row_ext[4:0];
      out_data.cursor_column   <= col_ext[6:0];
      out_data.did_scroll      <= scrolled;
      if (txc_op_t'(item.op) == OP_READ && idx_ok) begin
        out_data.cell_char  <= mem_rdata[7:0];
        out_data.cell_color <= mem_rdata[15:8];
      end else begin
        out_data.cell_char  <= '0;
        out_data.cell_color <= '0;
      end
    end
  end

endmodule

/* design/text_console_writer_top.sv */
// Text console writer: character-cell screen store with cursor and scrolling.
// Uses txc_pkg, txc_ctrl, txc_dp (which holds the txc_ram screen store).
//
// Input items (op, char_code, attribute, cell_index) transfer on in_valid with
// in_stall low; each gives exactly one result (cursor position, row, column,
// scroll flag, read cell) that transfers on out_valid with out_stall low.
// cfg_write loads cfg_data into the blank attribute used by clear and scroll.
// One item is in work at a time; the store has one write and one read port.
//   put character, no scroll : put step, then result
//   put causing a scroll     : put, then a sweep over COLUMNS*ROWS cells (one cell
//                              moved or blanked per cycle through the store ports)
//   clear screen             : fill over COLUMNS*ROWS cells (one cell per cycle)
//   read one cell            : registered store read, then result
//   unused op                : straight to result
// After reset a clearing pass over all COLUMNS*ROWS cells blanks the store with
// attribute 15; in_stall is high during it, configuration writes still land.
// A finished result waits in the output register while out_stall is high;
// the item has been accepted, so the block only holds back the next result.
module text_console_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  txc_pkg::txc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output txc_pkg::txc_out_t out_data
);
  import txc_pkg::*;

  txc_cmd_t    cmd;
  txc_status_t status;
  txc_state_t  state;

  txc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  txc_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // never overwrite a result that is still held
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result loaded over a held result");

  // an accepted item leaves idle on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != ST_IDLE))
    else $error("accepted item not started");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(out_data.cursor_column) < COLUMNS))
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(out_data.cursor_line) < ROWS))
    else $error("cursor row out of range");

  a_scroll_home: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.did_scroll) |-> (out_data.cursor_column == '0))
    else $error("scroll left cursor off column zero");

endmodule
